[src/vgcd_pkg.sv]
package vgcd_pkg;

    // volume limits and derived sizes
    localparam int MAX_WIDTH       = 128;
    localparam int MAX_HEIGHT      = 128;
    localparam int STORE_DEPTH_MIN = 2 * MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W          = $clog2(STORE_DEPTH_MIN);
    localparam int RING_DEPTH      = 1 << ADDR_W;
    localparam int WID_W           = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W           = $clog2(MAX_HEIGHT + 1);
    localparam int X_W             = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int Y_W             = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PLANE_W         = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    // field widths
    localparam int VOXEL_W   = 16;
    localparam int GRAD_W    = 8;
    localparam int REG_DIM_W = 8;
    localparam int DEPTH_W   = 16;
    localparam int CFG_W     = 16;

    // output buffer
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic signed [VOXEL_W-1:0] BORDER_RESET = -16'sd1024;

    typedef enum logic [0:0] {
        CMD_VOXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_VOL_WIDTH  = 2'd0,
        CFG_VOL_HEIGHT = 2'd1,
        CFG_VOL_DEPTH  = 2'd2,
        CFG_BORDER     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [GRAD_W-1:0] grad_x;
        logic [GRAD_W-1:0] grad_y;
        logic [GRAD_W-1:0] grad_z;
        logic              last;
    } t_result;

    // clamp(floor((next - prev + 255) / 2), 0, 255)
    function automatic logic [GRAD_W-1:0] grad_byte(input logic signed [VOXEL_W-1:0] prev,
                                                    input logic signed [VOXEL_W-1:0] next);
        logic signed [VOXEL_W+1:0] g;
        g = (VOXEL_W+2)'(next) - (VOXEL_W+2)'(prev) + (VOXEL_W+2)'(255);
        if (g < 0) begin
            return '0;
        end else if (g >= (VOXEL_W+2)'(512)) begin
            return '1;
        end else begin
            return g[GRAD_W:1];
        end
    endfunction

endpackage

[src/vgcd_in_if.sv]
interface vgcd_in_if;
    import vgcd_pkg::*;

    logic                       valid;
    logic                       ready;
    t_cmd                       cmd;
    logic signed [VOXEL_W-1:0]  voxel_value;

    modport source (output valid, output cmd, output voxel_value, input ready);
    modport sink   (input valid, input cmd, input voxel_value, output ready);
endinterface

[src/vgcd_out_if.sv]
interface vgcd_out_if;
    import vgcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [GRAD_W-1:0] grad_x;
    logic [GRAD_W-1:0] grad_y;
    logic [GRAD_W-1:0] grad_z;
    logic              last;

    modport source (output valid, output grad_x, output grad_y, output grad_z, output last,
                    input ready);
    modport sink   (input valid, input grad_x, input grad_y, input grad_z, input last,
                    output ready);
endinterface

[src/vgcd_ram.sv]
module vgcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // read-first on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

[src/volume_gradient_central_diff.sv]
// a voxel's result follows the transfer of the item one plane later via the read-data register
// throughput: one item per cycle unless input stalls; each item makes one write and four reads
// of the plane ring (two ring copies with two read ports each), one pass per item
// output side: 3-entry result buffer; input stalls while buffered plus in-flight results reach 3
// reset: synchronous, restores register defaults and clears all counters and flags
// the plane ring itself is not cleared; no value read from an unwritten entry is used
module volume_gradient_central_diff (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  vgcd_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [vgcd_pkg::CFG_W-1:0]    i_cfg_data,
    vgcd_in_if.sink                       i_vox,
    vgcd_out_if.source                    o_grad
);
    import vgcd_pkg::*;

    // control carried from the accept cycle to the read-data cycle
    typedef struct packed {
        logic                      valid;
        logic                      emit;
        logic                      last;
        logic                      x_first;
        logic                      x_last;
        logic                      y_first;
        logic                      y_last;
        logic                      z_first;
        logic signed [VOXEL_W-1:0] z_next;
    } t_s1_ctrl;

    // configuration, stored already clamped
    logic [WID_W-1:0]          r_vol_w,   n_vol_w;
    logic [HGT_W-1:0]          r_vol_h,   n_vol_h;
    logic [DEPTH_W-1:0]        r_vol_d,   n_vol_d;
    logic signed [VOXEL_W-1:0] r_border,  n_border;
    logic [PLANE_W-1:0]        r_plane,   n_plane;
    logic [REG_DIM_W-1:0]      cfg_dim;

    // input and output position
    logic [PLANE_W-1:0]        r_in_xy;
    logic [DEPTH_W-1:0]        r_in_z;
    logic [X_W-1:0]            r_out_x;
    logic [Y_W-1:0]            r_out_y;
    logic [DEPTH_W-1:0]        r_out_z;
    logic                      r_done;
    logic [ADDR_W-1:0]         r_wr_addr;

    // accept cycle
    logic                      in_fire;
    logic                      active;
    logic                      in_started;
    logic                      in_live;
    logic                      emit;
    logic                      x_last, y_last, z_last, vox_last;
    logic signed [VOXEL_W-1:0] cur;
    logic [ADDR_W-1:0]         base;
    logic [ADDR_W-1:0]         addr_a, addr_b, addr_c, addr_d;

    // read-data cycle
    t_s1_ctrl                  r_s1;
    logic [VOXEL_W-1:0]        rd_a, rd_b, rd_c, rd_d;
    logic [VOXEL_W-1:0]        r_xh1, r_xh2;
    logic signed [VOXEL_W-1:0] x1, x2, y1, y2, z1;
    t_result                   res;

    // result buffer
    t_result                   r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0]     r_count;
    logic                      push, pop;

    // ---------------------------------------------------------------
    // configuration writes: clamp on entry, refresh the plane size
    // ---------------------------------------------------------------
    assign cfg_dim = i_cfg_data[REG_DIM_W-1:0];

    always_comb begin
        n_vol_w  = r_vol_w;
        n_vol_h  = r_vol_h;
        n_vol_d  = r_vol_d;
        n_border = r_border;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VOL_WIDTH: begin
                    if (cfg_dim == '0) begin
                        n_vol_w = WID_W'(1);
                    end else if (32'(cfg_dim) > MAX_WIDTH) begin
                        n_vol_w = WID_W'(MAX_WIDTH);
                    end else begin
                        n_vol_w = WID_W'(cfg_dim);
                    end
                end
                CFG_VOL_HEIGHT: begin
                    if (cfg_dim == '0) begin
                        n_vol_h = HGT_W'(1);
                    end else if (32'(cfg_dim) > MAX_HEIGHT) begin
                        n_vol_h = HGT_W'(MAX_HEIGHT);
                    end else begin
                        n_vol_h = HGT_W'(cfg_dim);
                    end
                end
                CFG_VOL_DEPTH: begin
                    // zero planes acts as one
                    n_vol_d = (i_cfg_data[DEPTH_W-1:0] == '0) ? DEPTH_W'(1)
                                                               : i_cfg_data[DEPTH_W-1:0];
                end
                CFG_BORDER: begin
                    n_border = i_cfg_data[VOXEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
        n_plane = PLANE_W'(n_vol_w) * PLANE_W'(n_vol_h);
    end

    // ---------------------------------------------------------------
    // accept cycle: classify the item, issue ring reads, write ring
    // ---------------------------------------------------------------
    assign in_fire    = i_vox.valid && i_vox.ready;
    assign active     = in_fire && !r_done;
    assign in_started = (r_in_z != '0);        // at least one plane already in
    assign in_live    = (r_in_z < r_vol_d);    // item still inside the volume
    assign emit       = active && in_started;

    // a flush item, or data past the end, stands for the border value
    assign cur = (i_vox.cmd == CMD_VOXEL && in_live) ? i_vox.voxel_value : r_border;

    assign x_last   = (r_out_x == X_W'(r_vol_w - WID_W'(1)));
    assign y_last   = (r_out_y == Y_W'(r_vol_h - HGT_W'(1)));
    assign z_last   = (r_out_z == r_vol_d - DEPTH_W'(1));
    assign vox_last = x_last && y_last && z_last;

    // ring addresses around the voxel one plane back
    assign base   = r_wr_addr - ADDR_W'(r_plane);
    assign addr_a = base + ADDR_W'(1);          // next along x
    assign addr_b = base + ADDR_W'(r_vol_w);    // next along y
    assign addr_c = base - ADDR_W'(r_vol_w);    // previous along y
    assign addr_d = base - ADDR_W'(r_plane);    // previous along z

    // two identical copies of the ring, two read ports each
    vgcd_ram #(
        .WIDTH (VOXEL_W),
        .DEPTH (RING_DEPTH)
    ) u_ram_0 (
        .i_clk     (i_clk),
        .i_we      (active),
        .i_waddr   (r_wr_addr),
        .i_wdata   (cur),
        .i_re      (active),
        .i_raddr_a (addr_a),
        .i_raddr_b (addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    vgcd_ram #(
        .WIDTH (VOXEL_W),
        .DEPTH (RING_DEPTH)
    ) u_ram_1 (
        .i_clk     (i_clk),
        .i_we      (active),
        .i_waddr   (r_wr_addr),
        .i_wdata   (cur),
        .i_re      (active),
        .i_raddr_a (addr_c),
        .i_raddr_b (addr_d),
        .o_rdata_a (rd_c),
        .o_rdata_b (rd_d)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_w   <= WID_W'(1);
            r_vol_h   <= HGT_W'(1);
            r_vol_d   <= DEPTH_W'(1);
            r_border  <= BORDER_RESET;
            r_plane   <= PLANE_W'(1);
            r_in_xy   <= '0;
            r_in_z    <= '0;
            r_out_x   <= '0;
            r_out_y   <= '0;
            r_out_z   <= '0;
            r_done    <= 1'b0;
            r_wr_addr <= '0;
            r_s1      <= '0;
        end else begin
            r_vol_w  <= n_vol_w;
            r_vol_h  <= n_vol_h;
            r_vol_d  <= n_vol_d;
            r_border <= n_border;
            r_plane  <= n_plane;

            r_s1.valid   <= active;
            r_s1.emit    <= emit;
            r_s1.last    <= vox_last;
            r_s1.x_first <= (r_out_x == '0);
            r_s1.x_last  <= x_last;
            r_s1.y_first <= (r_out_y == '0);
            r_s1.y_last  <= y_last;
            r_s1.z_first <= (r_out_z == '0);
            r_s1.z_next  <= z_last ? r_border : cur;

            if (i_cfg_we) begin
                // any register write restarts the volume
                r_in_xy   <= '0;
                r_in_z    <= '0;
                r_out_x   <= '0;
                r_out_y   <= '0;
                r_out_z   <= '0;
                r_done    <= 1'b0;
                r_wr_addr <= '0;
            end else begin
                if (active) begin
                    r_wr_addr <= r_wr_addr + ADDR_W'(1);
                    if (r_in_xy == r_plane - PLANE_W'(1)) begin
                        r_in_xy <= '0;
                        if (in_live) begin
                            r_in_z <= r_in_z + DEPTH_W'(1);
                        end
                    end else begin
                        r_in_xy <= r_in_xy + PLANE_W'(1);
                    end
                end
                if (emit) begin
                    if (vox_last) begin
                        r_done <= 1'b1;
                    end else if (x_last) begin
                        r_out_x <= '0;
                        if (y_last) begin
                            r_out_y <= '0;
                            r_out_z <= r_out_z + DEPTH_W'(1);
                        end else begin
                            r_out_y <= r_out_y + Y_W'(1);
                        end
                    end else begin
                        r_out_x <= r_out_x + X_W'(1);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // read-data cycle: previous x neighbor from a two-deep history of
    // the next-along-x read stream, the rest straight from the ring
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_s1.valid) begin
            r_xh1 <= rd_a;
            r_xh2 <= r_xh1;
        end
    end

    assign x1 = r_s1.x_first ? r_border : $signed(r_xh2);
    assign x2 = r_s1.x_last  ? r_border : $signed(rd_a);
    assign y1 = r_s1.y_first ? r_border : $signed(rd_c);
    assign y2 = r_s1.y_last  ? r_border : $signed(rd_b);
    assign z1 = r_s1.z_first ? r_border : $signed(rd_d);

    always_comb begin
        res.grad_x = grad_byte(x1, x2);
        res.grad_y = grad_byte(y1, y2);
        res.grad_z = grad_byte(z1, r_s1.z_next);
        res.last   = r_s1.last;
    end

    // ---------------------------------------------------------------
    // result buffer; outside reset, input is held back only when the
    // items in flight could overflow it
    // ---------------------------------------------------------------
    assign push = r_s1.emit;
    assign pop  = o_grad.valid && o_grad.ready;

    assign i_vox.ready = i_rst_n &&
        ((FIFO_CNT_W+1)'(r_count) + (FIFO_CNT_W+1)'(r_s1.emit) < (FIFO_CNT_W+1)'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

    assign o_grad.valid  = (r_count != '0);
    assign o_grad.grad_x = r_fifo[r_rd_ptr].grad_x;
    assign o_grad.grad_y = r_fifo[r_rd_ptr].grad_y;
    assign o_grad.grad_z = r_fifo[r_rd_ptr].grad_z;
    assign o_grad.last   = r_fifo[r_rd_ptr].last;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (r_count < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result buffer overflow");

    a_emit_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.emit |-> $past(in_fire && !r_done))
        else $error("result without a live transfer one cycle earlier");

    a_done_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && in_fire) |=> !r_s1.valid)
        else $error("item processed after the final voxel");

    a_last_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && vox_last && !i_cfg_we) |=> r_done)
        else $error("final voxel did not close the volume");

endmodule
